// ===== sv/pss_pkg.sv =====
package pss_pkg;

    localparam int unsigned HistoryBitsDef = 16;
    localparam int unsigned UvBits         = 3;
    localparam int unsigned IntervalW      = 16;
    localparam int unsigned OffCountW      = 5;
    localparam int unsigned CfgIndexW      = 3;
    localparam int unsigned CfgDataW       = 16;

    localparam logic [IntervalW-1:0] CheckIntervalRst = 16'd10;
    localparam logic [OffCountW-1:0] OffCountRst      = 5'd10;
    localparam logic [IntervalW-1:0] BlinkHalfRst     = 16'd500;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_SWITCH   = 2'd1,
        EV_LOW_VOLT = 2'd2
    } event_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_CHECK_INTERVAL = 3'd0,
        REG_OFF_COUNT      = 3'd1,
        REG_BLINK_HALF     = 3'd2,
        REG_HEARTBEAT_EN   = 3'd3,
        REG_PWR_MGR_EN     = 3'd4
    } cfg_reg_t;

    function automatic logic [IntervalW-1:0] reload_of(input logic [IntervalW-1:0] interval);
        logic [IntervalW-1:0] r;
        r = (interval == '0) ? '0 : interval - 1'b1;
        return r;
    endfunction

endpackage

// ===== sv/power_switch_supervisor.sv =====
// Power switch / undervoltage supervisor with heartbeat LED.
// Input channel (s_valid/s_ready): one request per millisecond tick, carrying
// the sampled switch pin (0 = pressed) and undervoltage pin (0 = low supply).
// Result channel (m_valid/m_ready): exactly one result per request, giving the
// event code (none, switch power-off, low-voltage power-off), the hold pin and
// the LED pin as they stand after that tick.
// Configuration channel (cfg_valid/cfg_ready): register index and data; always
// ready. The user must write it only with no tick in flight; the block does
// not enforce this. Interval changes take effect at the next countdown reload.
// The result of a tick is registered and shows on m_* in the cycle after the
// request is accepted. Throughput: one tick per cycle while results are taken,
// set by the single output register, refilled in the cycle it is taken.
// When the receiver stalls, the pending result holds and s_ready drops until
// it is taken; no tick is lost.
// Reset (aresetn low, synchronous): registers to their defaults, supply held,
// LED on, both histories all ones, check due on the first tick. After a
// power-off the block stays off (hold 0, LED 0, no events) until reset.
module power_switch_supervisor
    import pss_pkg::*;
#(
    parameter int unsigned HISTORY_BITS = HistoryBitsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_switch_level,
    input  logic                 s_undervolt_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_event_code,
    output logic                 m_hold_pin,
    output logic                 m_led_pin,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // configuration
    logic [IntervalW-1:0] check_interval_reg;
    logic [OffCountW-1:0] off_count_reg;
    logic [IntervalW-1:0] blink_half_reg;
    logic                 heartbeat_en_reg;
    logic                 pwr_mgr_en_reg;

    // tick state
    logic [IntervalW-1:0]    check_cnt_reg, check_cnt_next;
    logic [IntervalW-1:0]    blink_cnt_reg, blink_cnt_next;
    logic [HISTORY_BITS-1:0] sw_hist_reg, sw_hist_next;
    logic [UvBits-1:0]       uv_hist_reg, uv_hist_next;
    logic                    led_phase_reg, led_phase_next;
    logic                    led_level_reg, led_level_next;
    logic                    powered_reg, powered_next;

    // result register
    logic   m_valid_reg;
    event_t event_reg, event_next;
    logic   hold_reg;
    logic   led_reg;

    logic                    s_accept;
    logic                    cfg_accept;
    logic [HISTORY_BITS-1:0] hist_mask;
    logic [HISTORY_BITS:0]   sw_shift_wide;
    logic [HISTORY_BITS-1:0] sw_shifted;
    logic [UvBits-1:0]       uv_shifted;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign m_valid      = m_valid_reg;
    assign m_event_code = event_reg;
    assign m_hold_pin   = hold_reg;
    assign m_led_pin    = led_reg;

    // off count clamped to 1..HISTORY_BITS: bit 0 always kept
    always_comb begin
        for (int i = 0; i < HISTORY_BITS; i++) begin
            hist_mask[i] = (i == 0) || (32'(off_count_reg) > i);
        end
    end

    assign sw_shift_wide = {sw_hist_reg, s_switch_level};
    assign sw_shifted    = sw_shift_wide[HISTORY_BITS-1:0] & hist_mask;
    assign uv_shifted    = {uv_hist_reg[UvBits-2:0], s_undervolt_level};

    always_comb begin
        check_cnt_next = check_cnt_reg;
        blink_cnt_next = blink_cnt_reg;
        sw_hist_next   = sw_hist_reg;
        uv_hist_next   = uv_hist_reg;
        led_phase_next = led_phase_reg;
        led_level_next = led_level_reg;
        powered_next   = powered_reg;
        event_next     = EV_NONE;

        if (powered_reg && pwr_mgr_en_reg) begin
            if (check_cnt_reg == '0) begin
                check_cnt_next = reload_of(check_interval_reg);
                sw_hist_next   = sw_shifted;
                if (sw_shifted == '0) begin
                    event_next = EV_SWITCH;
                end else begin
                    uv_hist_next = uv_shifted;
                    if (uv_shifted == '0) begin
                        event_next = EV_LOW_VOLT;
                    end
                end
            end else begin
                check_cnt_next = check_cnt_reg - 1'b1;
            end
        end

        if (event_next != EV_NONE) begin
            sw_hist_next   = '1;
            uv_hist_next   = '1;
            led_level_next = 1'b0;
            powered_next   = 1'b0;
        end

        // heartbeat skipped on the power-off tick
        if (powered_next && heartbeat_en_reg) begin
            if (blink_cnt_reg == '0) begin
                blink_cnt_next = reload_of(blink_half_reg);
                led_phase_next = !led_phase_reg;
                led_level_next = !led_phase_reg;
            end else begin
                blink_cnt_next = blink_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_interval_reg <= CheckIntervalRst;
            off_count_reg      <= OffCountRst;
            blink_half_reg     <= BlinkHalfRst;
            heartbeat_en_reg   <= 1'b1;
            pwr_mgr_en_reg     <= 1'b1;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                REG_CHECK_INTERVAL: check_interval_reg <= cfg_data;
                REG_OFF_COUNT:      off_count_reg      <= cfg_data[OffCountW-1:0];
                REG_BLINK_HALF:     blink_half_reg     <= cfg_data;
                REG_HEARTBEAT_EN:   heartbeat_en_reg   <= cfg_data[0];
                REG_PWR_MGR_EN:     pwr_mgr_en_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_cnt_reg <= '0;
            blink_cnt_reg <= BlinkHalfRst;
            sw_hist_reg   <= '1;
            uv_hist_reg   <= '1;
            led_phase_reg <= 1'b0;
            led_level_reg <= 1'b1;
            powered_reg   <= 1'b1;
        end else if (s_accept) begin
            check_cnt_reg <= check_cnt_next;
            blink_cnt_reg <= blink_cnt_next;
            sw_hist_reg   <= sw_hist_next;
            uv_hist_reg   <= uv_hist_next;
            led_phase_reg <= led_phase_next;
            led_level_reg <= led_level_next;
            powered_reg   <= powered_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            event_reg <= event_next;
            hold_reg  <= powered_next;
            led_reg   <= led_level_next;
        end
    end

`ifndef SYNTHESIS
    a_stays_off: assert property (@(posedge aclk) disable iff (!aresetn)
        !powered_reg |=> !powered_reg)
        else $error("supply re-enabled without reset");

    a_off_led_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        !powered_reg |-> !led_level_reg)
        else $error("LED lit while powered off");

    a_event_drops_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && event_reg != EV_NONE |-> !hold_reg)
        else $error("power-off event with hold still high");

    a_fall_has_event: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(powered_reg) |-> m_valid_reg && event_reg != EV_NONE)
        else $error("power released without an event");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pss_pkg::*;

    typedef struct {
        logic [IntervalW-1:0] check_ivl;
        logic [OffCountW-1:0] off_cnt;
        logic [IntervalW-1:0] blink_ivl;
        logic                 hb_en;
        logic                 pm_en;
    } sup_regs_t;

    typedef struct {
        logic [IntervalW-1:0]      check_cd;
        logic [IntervalW-1:0]      blink_cd;
        logic [HistoryBitsDef-1:0] sw_hist;
        logic [UvBits-1:0]         uv_hist;
        logic                      phase;
        logic                      led;
        logic                      powered;
        event_t                    ev;
    } sup_state_t;

    typedef struct packed {
        event_t ev;
        logic   hold;
        logic   led;
    } pins_t;

    typedef struct packed {
        logic  sw;
        logic  uv;
        logic  typed;
        pins_t pins;
    } tick_req_t;

    typedef enum {NOISE, PRESS, BROWNOUT} burst_t;

    logic                 aclk;
    logic                 aresetn           = 1'b0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic                 s_switch_level    = 1'b1;
    logic                 s_undervolt_level = 1'b1;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [1:0]           m_event_code;
    logic                 m_hold_pin;
    logic                 m_led_pin;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index         = '0;
    logic [CfgDataW-1:0]  cfg_data          = '0;

    sup_regs_t   regs;
    sup_state_t  offered_st;   // state after every request handed to the driver
    sup_state_t  accepted_st;  // state after every request the block took
    tick_req_t   row_tags [$];
    pins_t       exp_pins [$];
    tick_req_t   dir_tab [25];
    int unsigned mismatches = 0;
    int unsigned ticks_in   = 0;
    bit          quiet      = 1'b0;
    bit          held       = 1'b0;

    power_switch_supervisor uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_switch_level    (s_switch_level),
        .s_undervolt_level (s_undervolt_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_code      (m_event_code),
        .m_hold_pin        (m_hold_pin),
        .m_led_pin         (m_led_pin),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("** power_switch_supervisor: FAILED **");
        $finish;
    end

    // One millisecond tick of the supervisor.
    function automatic sup_state_t supervise(input sup_state_t s, input logic sw,
                                             input logic uv);
        int unsigned               n;
        logic [31:0]               m32;
        logic [HistoryBitsDef-1:0] mask;
        n = regs.off_cnt;
        if (n < 1) n = 1;
        if (n > HistoryBitsDef) n = HistoryBitsDef;
        m32 = (32'd1 << n) - 32'd1;
        mask = m32[HistoryBitsDef-1:0];
        s.ev = EV_NONE;
        if (s.powered && regs.pm_en) begin
            if (s.check_cd == '0) begin
                s.check_cd = (regs.check_ivl == '0) ? '0 : regs.check_ivl - 16'd1;
                s.sw_hist = ((s.sw_hist << 1) & mask) | sw;
                if (s.sw_hist == '0) begin
                    s.ev = EV_SWITCH;
                end else begin
                    s.uv_hist = {s.uv_hist[UvBits-2:0], uv};
                    if (s.uv_hist == '0) s.ev = EV_LOW_VOLT;
                end
                if (s.ev != EV_NONE) begin
                    s.sw_hist = '1;
                    s.uv_hist = '1;
                    s.led = 1'b0;
                    s.powered = 1'b0;
                end
            end else begin
                s.check_cd = s.check_cd - 16'd1;
            end
        end
        // heartbeat is skipped on the release tick since powered has just dropped
        if (s.powered && regs.hb_en) begin
            if (s.blink_cd == '0) begin
                s.blink_cd = (regs.blink_ivl == '0) ? '0 : regs.blink_ivl - 16'd1;
                s.phase = ~s.phase;
                s.led = s.phase;
            end else begin
                s.blink_cd = s.blink_cd - 16'd1;
            end
        end
        return s;
    endfunction

    always @(posedge aclk) begin : scoreboard
        tick_req_t tag;
        pins_t     want;
        if (aresetn && s_valid && s_ready) begin
            tag = row_tags.pop_front();
            accepted_st = supervise(accepted_st, s_switch_level, s_undervolt_level);
            ticks_in++;
            want = {accepted_st.ev, accepted_st.powered, accepted_st.led};
            exp_pins.push_back(tag.typed ? tag.pins : want);
        end
        if (aresetn && m_valid && m_ready) begin
            if (exp_pins.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with nothing pending: ev %0d hold %0b led %0b",
                             $realtime, m_event_code, m_hold_pin, m_led_pin);
                mismatches++;
            end else begin
                want = exp_pins.pop_front();
                if (m_event_code !== want.ev || m_hold_pin !== want.hold ||
                    m_led_pin !== want.led) begin
                    if (mismatches < 10)
                        $display({"%0t: mismatch: ev exp %0d got %0d, hold exp %0b got %0b,",
                                  " led exp %0b got %0b"}, $realtime, want.ev, m_event_code,
                                 want.hold, m_hold_pin, want.led, m_led_pin);
                    mismatches++;
                end
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off to fill the block.
    initial begin : result_sink
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && ticks_in >= 700) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (250) @(posedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 8);
                @(posedge aclk);
            end
        end
    end

    task automatic offer(input tick_req_t req);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        row_tags.push_back(req);
        offered_st = supervise(offered_st, req.sw, req.uv);
        s_valid           <= 1'b1;
        s_switch_level    <= req.sw;
        s_undervolt_level <= req.uv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (exp_pins.size() != 0 || row_tags.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CHECK_INTERVAL: regs.check_ivl = d;
            REG_OFF_COUNT:      regs.off_cnt   = d[OffCountW-1:0];
            REG_BLINK_HALF:     regs.blink_ivl = d;
            REG_HEARTBEAT_EN:   regs.hb_en     = d[0];
            REG_PWR_MGR_EN:     regs.pm_en     = d[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] chk, input logic [4:0] off,
                                input logic [15:0] blk, input logic hb, input logic pm);
        write_reg(REG_CHECK_INTERVAL, chk);
        write_reg(REG_OFF_COUNT, {11'd0, off});
        write_reg(REG_BLINK_HALF, blk);
        write_reg(REG_HEARTBEAT_EN, {15'd0, hb});
        write_reg(REG_PWR_MGR_EN, {15'd0, pm});
        cfg_valid <= 1'b0;
    endtask

    // Press and brownout bursts run right up to the release threshold; the
    // sample that would release power is turned into an idle one instead.
    task automatic run_random(input int n);
        burst_t     mode;
        int         left;
        int         span;
        int         eff_off;
        logic       sw;
        logic       uv;
        sup_state_t nxt;
        mode = NOISE;
        left = 0;
        repeat (n) begin
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0:       mode = NOISE;
                    1, 2:    mode = PRESS;
                    default: mode = BROWNOUT;
                endcase
                eff_off = (regs.off_cnt == 0) ? 1 :
                          (regs.off_cnt > HistoryBitsDef) ? HistoryBitsDef : regs.off_cnt;
                span = ((regs.check_ivl == '0) ? 1 : regs.check_ivl) * (eff_off + 2);
                if (span > 200) span = 200;
                left = $urandom_range(1, span);
            end
            left--;
            case (mode)
                PRESS: begin
                    sw = ($urandom_range(0, 15) == 0);
                    uv = ($urandom_range(0, 7) != 0);
                end
                BROWNOUT: begin
                    sw = ($urandom_range(0, 15) != 0);
                    uv = ($urandom_range(0, 15) == 0);
                end
                default: begin
                    sw = $urandom_range(0, 1);
                    uv = $urandom_range(0, 1);
                end
            endcase
            nxt = supervise(offered_st, sw, uv);
            if (nxt.ev != EV_NONE) begin
                sw = 1'b1;
                uv = 1'b1;
            end
            offer({sw, uv, 1'b0, 4'd0});
        end
    endtask

    initial begin : stimulus
        logic sw_kind;
        int   i;

        // Checks fall on rows 0, 10 and 20 at the reset interval.
        dir_tab[0]  = {1'b0, 1'b0, 1'b1, EV_NONE, 1'b1, 1'b1};
        dir_tab[1]  = {1'b1, 1'b1, 1'b1, EV_NONE, 1'b1, 1'b1};
        dir_tab[2]  = {1'b0, 1'b1, 1'b1, EV_NONE, 1'b1, 1'b1};
        dir_tab[3]  = {1'b1, 1'b0, 1'b1, EV_NONE, 1'b1, 1'b1};
        dir_tab[4]  = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[5]  = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[6]  = {1'b1, 1'b1, 1'b0, 4'd0};
        dir_tab[7]  = {1'b0, 1'b1, 1'b0, 4'd0};
        dir_tab[8]  = {1'b1, 1'b0, 1'b0, 4'd0};
        dir_tab[9]  = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[10] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[11] = {1'b1, 1'b1, 1'b0, 4'd0};
        dir_tab[12] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[13] = {1'b1, 1'b0, 1'b0, 4'd0};
        dir_tab[14] = {1'b0, 1'b1, 1'b0, 4'd0};
        dir_tab[15] = {1'b1, 1'b1, 1'b0, 4'd0};
        dir_tab[16] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[17] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[18] = {1'b1, 1'b0, 1'b0, 4'd0};
        dir_tab[19] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[20] = {1'b0, 1'b1, 1'b0, 4'd0};
        dir_tab[21] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[22] = {1'b1, 1'b1, 1'b0, 4'd0};
        dir_tab[23] = {1'b0, 1'b0, 1'b0, 4'd0};
        dir_tab[24] = {1'b1, 1'b0, 1'b0, 4'd0};

        regs.check_ivl = CheckIntervalRst;
        regs.off_cnt   = OffCountRst;
        regs.blink_ivl = BlinkHalfRst;
        regs.hb_en     = 1'b1;
        regs.pm_en     = 1'b1;
        offered_st.check_cd = '0;
        offered_st.blink_cd = BlinkHalfRst;
        offered_st.sw_hist  = '1;
        offered_st.uv_hist  = '1;
        offered_st.phase    = 1'b0;
        offered_st.led      = 1'b1;
        offered_st.powered  = 1'b1;
        offered_st.ev       = EV_NONE;
        accepted_st = offered_st;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 25; i++) offer(dir_tab[i]);
        run_random(150);
        settle();

        quiet = 1'b1;
        program_regs(16'd1, 5'd16, 16'd3, 1'b1, 1'b1);
        run_random(250);
        settle();
        quiet = 1'b0;

        // zero off count acts as one, zero blink interval toggles every tick
        program_regs(16'd2, 5'd0, 16'd0, 1'b1, 1'b1);
        run_random(150);
        settle();

        // off count above the history length, heartbeat frozen
        program_regs(16'd0, 5'd31, 16'd7, 1'b0, 1'b1);
        run_random(200);
        settle();

        // monitoring frozen
        program_regs(16'd3, 5'd5, 16'd2, 1'b1, 1'b0);
        run_random(150);
        settle();

        repeat (5) begin
            program_regs($urandom_range(0, 6), $urandom_range(0, 20), $urandom_range(0, 20),
                         $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            run_random(150);
            settle();
        end

        // Both countdowns end up firing every tick, so with the longest intervals
        // below the release falls on a tick where a blink toggle was due.
        program_regs(16'd0, $urandom_range(1, 16), 16'd1, 1'b1, 1'b1);
        run_random(100);
        settle();

        // two low supply samples, so the next check can release on either cause
        while (offered_st.uv_hist[UvBits-2:0] != 2'b00)
            offer({1'b1, 1'b0, 1'b0, 4'd0});
        settle();

        quiet = 1'b1;
        program_regs(16'hffff, 5'd0, 16'hffff, 1'b1, 1'b1);
        sw_kind = $urandom_range(0, 1);
        while (offered_st.powered)
            offer({~sw_kind, sw_kind, 1'b0, 4'd0});
        quiet = 1'b0;
        run_random(30);
        settle();

        if (mismatches == 0)
            $display("** power_switch_supervisor: PASSED **");
        else
            $display("** power_switch_supervisor: FAILED **");
        $finish;
    end

endmodule
